[rtl/jcru_pkg.sv]
// ----------------------------------------------------------------------------
// jcru_pkg
// Shared types, constants and small arithmetic helpers of the chroma
// replicate upsampler.
// ----------------------------------------------------------------------------
package jcru_pkg;

	localparam int BLOCK_DIM    = 8;
	localparam int PX_W         = 8;
	localparam int MAX_SAMPLING = 4;
	localparam int NUM_REGS     = 6;
	localparam int QUEUE_DEPTH  = 2;
	localparam int REG_IDX_W    = 3;
	localparam int FACTOR_W     = 3;

	localparam logic [REG_IDX_W-1:0] REG_LUMA_H = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LUMA_V = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CB_H   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CB_V   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CR_H   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CR_V   = 3'd5;

	typedef logic [FACTOR_W-1:0]        factor_t;
	typedef logic [3:0]                 blk_t;
	typedef logic [2:0]                 row_t;
	typedef logic [PX_W-1:0]            px_t;
	typedef px_t [BLOCK_DIM-1:0]        px_row_t;

	// one classified input row, ready for replication
	typedef struct packed {
		logic    component;
		factor_t fh;
		factor_t fv;
		factor_t yh;
		blk_t    dx0;
		blk_t    dy0;
		logic [4:0] r0;
		px_row_t px;
	} job_t;

	function automatic factor_t clamp_factor(input factor_t v);
		if (v == 3'd0)
			return 3'd1;
		if (v > FACTOR_W'(MAX_SAMPLING))
			return FACTOR_W'(MAX_SAMPLING);
		return v;
	endfunction

	// floor(v / d) for d in 1..4, v < 32; divide by 3 via 11/32
	function automatic logic [4:0] quot_small(input logic [4:0] v, input factor_t d);
		logic [9:0] p;
		p = 10'(v) * 10'd11;
		case (d)
			3'd1: return v;
			3'd2: return v >> 1;
			3'd3: return p[9:5];
			3'd4: return v >> 2;
			default: return v;
		endcase
	endfunction

	function automatic factor_t ratio(input factor_t luma, input factor_t chroma);
		logic [4:0] q;
		q = quot_small(5'(clamp_factor(luma)), clamp_factor(chroma));
		return (q == 5'd0) ? 3'd1 : q[2:0];
	endfunction

endpackage

[rtl/jcru_if.sv]
// ----------------------------------------------------------------------------
// jcru interfaces
// Valid/ready channels for input rows, output rows and register writes.
// ----------------------------------------------------------------------------
interface jcru_in_if;
	logic       valid;
	logic       ready;
	logic       component;
	logic [3:0] src_block;
	logic [2:0] src_row;
	logic [7:0] in_px0;
	logic [7:0] in_px1;
	logic [7:0] in_px2;
	logic [7:0] in_px3;
	logic [7:0] in_px4;
	logic [7:0] in_px5;
	logic [7:0] in_px6;
	logic [7:0] in_px7;

	modport source (
		output valid, component, src_block, src_row,
		       in_px0, in_px1, in_px2, in_px3, in_px4, in_px5, in_px6, in_px7,
		input  ready
	);
	modport sink (
		input  valid, component, src_block, src_row,
		       in_px0, in_px1, in_px2, in_px3, in_px4, in_px5, in_px6, in_px7,
		output ready
	);
endinterface

interface jcru_out_if;
	logic       valid;
	logic       ready;
	logic       out_component;
	logic [3:0] dest_block;
	logic [2:0] dest_row;
	logic [7:0] out_px0;
	logic [7:0] out_px1;
	logic [7:0] out_px2;
	logic [7:0] out_px3;
	logic [7:0] out_px4;
	logic [7:0] out_px5;
	logic [7:0] out_px6;
	logic [7:0] out_px7;
	logic       last_of_run;

	modport source (
		output valid, out_component, dest_block, dest_row,
		       out_px0, out_px1, out_px2, out_px3, out_px4, out_px5, out_px6, out_px7,
		       last_of_run,
		input  ready
	);
	modport sink (
		input  valid, out_component, dest_block, dest_row,
		       out_px0, out_px1, out_px2, out_px3, out_px4, out_px5, out_px6, out_px7,
		       last_of_run,
		output ready
	);
endinterface

interface jcru_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [2:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/jcru_front.sv]
// ----------------------------------------------------------------------------
// jcru_front
// Holds the sampling-factor registers, accepts input rows and classifies
// each into a replication job (factors, base block position, base row).
// ----------------------------------------------------------------------------
module jcru_front (
	input  logic            clk,
	input  logic            arst_n,
	jcru_in_if.sink         src,
	jcru_cfg_if.sink        cfg,
	output logic            push_valid,
	input  logic            push_ready,
	output jcru_pkg::job_t  push_job
);
	import jcru_pkg::*;

	factor_t luma_h_q, luma_v_q, cb_h_q, cb_v_q, cr_h_q, cr_v_q;

	factor_t    ch, cv, fh, fv, yh;
	logic [4:0] by5;
	blk_t       by;
	logic [6:0] by_ch;
	logic [1:0] bx;
	logic [4:0] bx_fh;
	logic [6:0] by_fv;
	logic [5:0] row_fv;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_h_q <= 3'd2;
			luma_v_q <= 3'd2;
			cb_h_q   <= 3'd1;
			cb_v_q   <= 3'd1;
			cr_h_q   <= 3'd1;
			cr_v_q   <= 3'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LUMA_H: luma_h_q <= cfg.data;
				REG_LUMA_V: luma_v_q <= cfg.data;
				REG_CB_H:   cb_h_q   <= cfg.data;
				REG_CB_V:   cb_v_q   <= cfg.data;
				REG_CR_H:   cr_h_q   <= cfg.data;
				REG_CR_V:   cr_v_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ch     = clamp_factor(src.component ? cr_h_q : cb_h_q);
		cv     = src.component ? cr_v_q : cb_v_q;
		yh     = clamp_factor(luma_h_q);
		fh     = ratio(luma_h_q, ch);
		fv     = ratio(luma_v_q, cv);
		by5    = quot_small({1'b0, src.src_block}, ch);
		by     = by5[3:0];
		by_ch  = 7'(by) * 7'(ch);
		bx     = 2'(src.src_block - by_ch[3:0]);
		bx_fh  = 5'(bx) * 5'(fh);
		by_fv  = 7'(by) * 7'(fv);
		row_fv = 6'(src.src_row) * 6'(fv);
	end

	always_comb begin
		push_job.component = src.component;
		push_job.fh        = fh;
		push_job.fv        = fv;
		push_job.yh        = yh;
		push_job.dx0       = bx_fh[3:0];
		push_job.dy0       = by_fv[3:0];
		push_job.r0        = row_fv[4:0];
		push_job.px[0]     = src.in_px0;
		push_job.px[1]     = src.in_px1;
		push_job.px[2]     = src.in_px2;
		push_job.px[3]     = src.in_px3;
		push_job.px[4]     = src.in_px4;
		push_job.px[5]     = src.in_px5;
		push_job.px[6]     = src.in_px6;
		push_job.px[7]     = src.in_px7;
	end

	assign push_valid = src.valid;
	assign src.ready  = push_ready;

endmodule

[rtl/jcru_queue.sv]
// ----------------------------------------------------------------------------
// jcru_queue
// Short job queue between the classifying front and the replicating back.
// ----------------------------------------------------------------------------
module jcru_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  jcru_pkg::job_t  push_job,
	output logic            head_valid,
	input  logic            pop,
	output jcru_pkg::job_t  head_job
);
	import jcru_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

[rtl/jcru_back.sv]
// ----------------------------------------------------------------------------
// jcru_back
// Walks each job over its vertical and horizontal replicas, one output
// row per cycle while dst is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module jcru_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  jcru_pkg::job_t  head_job,
	output logic            pop,
	jcru_out_if.source      dst
);
	import jcru_pkg::*;

	typedef struct packed {
		logic    component;
		blk_t    dest_block;
		row_t    dest_row;
		px_row_t px;
		logic    last;
	} result_t;

	logic [1:0] k_q, mx_q;
	logic       out_valid_q;
	result_t    out_q;

	logic       adv, last_k, last_mx, last;
	logic [4:0] r;
	blk_t       dx, dy;
	logic [6:0] dy_yh;
	logic [4:0] col;
	logic [4:0] src_col;
	result_t    nxt;

	assign adv     = !out_valid_q || dst.ready;
	assign last_mx = ({1'b0, mx_q} == head_job.fh - 3'd1);
	assign last_k  = ({1'b0, k_q} == head_job.fv - 3'd1);
	assign last    = last_mx && last_k;
	assign pop     = adv && head_valid && last;

	always_comb begin
		r     = head_job.r0 + 5'(k_q);
		dx    = head_job.dx0 + 4'(mx_q);
		dy    = head_job.dy0 + 4'(r[4:3]);
		dy_yh = 7'(dy) * 7'(head_job.yh);
		nxt.component  = head_job.component;
		nxt.dest_block = dy_yh[3:0] + dx;
		nxt.dest_row   = r[2:0];
		nxt.last       = last;
		for (int j = 0; j < BLOCK_DIM; j++) begin
			col         = {mx_q, 3'(j)};
			src_col     = quot_small(col, head_job.fh);
			nxt.px[j]   = head_job.px[src_col[2:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
			mx_q        <= '0;
		end else if (adv) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				if (last) begin
					k_q  <= '0;
					mx_q <= '0;
				end else if (last_mx) begin
					mx_q <= '0;
					k_q  <= k_q + 2'd1;
				end else begin
					mx_q <= mx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid)
			out_q <= nxt;
	end

	assign dst.valid         = out_valid_q;
	assign dst.out_component = out_q.component;
	assign dst.dest_block    = out_q.dest_block;
	assign dst.dest_row      = out_q.dest_row;
	assign dst.out_px0       = out_q.px[0];
	assign dst.out_px1       = out_q.px[1];
	assign dst.out_px2       = out_q.px[2];
	assign dst.out_px3       = out_q.px[3];
	assign dst.out_px4       = out_q.px[4];
	assign dst.out_px5       = out_q.px[5];
	assign dst.out_px6       = out_q.px[6];
	assign dst.out_px7       = out_q.px[7];
	assign dst.last_of_run   = out_q.last;

endmodule

[rtl/jpeg_chroma_replicate_upsampler_core.sv]
// ----------------------------------------------------------------------------
// jpeg_chroma_replicate_upsampler_core
// Chroma upsampler by pixel replication for Cb/Cr 8x8 block rows.
// ----------------------------------------------------------------------------
// Channels: src takes one subsampled 8-sample chroma row with its component,
// source block and row; dst returns fh*fv full-resolution rows, each with
// destination block and row, last_of_run marking the final one of a row.
// cfg writes the six sampling-factor registers (index 0..5); it is always
// ready. The user must see that it is written only while the block is
// idle; the block itself does not enforce this. Accepted input rows are
// held in the job queue. The back end emits one output row per cycle
// while dst is ready, fh*fv rows per input row (1 to 16; four for 4:2:0).
// A two-entry job queue lets the input side keep accepting rows while the
// back end works, and the output register holds a row while dst stalls;
// src.ready drops once the queue is full.
// Reset: queue and output stage empty, factors at luma 2x2, chroma 1x1.
// ----------------------------------------------------------------------------
module jpeg_chroma_replicate_upsampler_core (
	input  logic       clk,
	input  logic       arst_n,
	jcru_in_if.sink    src,
	jcru_out_if.source dst,
	jcru_cfg_if.sink   cfg
);
	import jcru_pkg::*;

	logic push_valid, push_ready, head_valid, pop;
	job_t push_job, head_job;

	jcru_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src        (src),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	jcru_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.head_valid (head_valid),
		.pop        (pop),
		.head_job   (head_job)
	);

	jcru_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.dst        (dst)
	);

endmodule
